>>> src/asr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asr_pkg
// Shared widths, codes, state encoding and controller/datapath interface types
// for the linear attack-sustain-release envelope generator.
// ----------------------------------------------------------------------------
package asr_pkg;

  localparam int TIME_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int LEVEL_W   = FRAC_W + 1;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = 6;

  localparam logic [CFG_W-1:0]     DUR_RESET   = CFG_W'(1000);
  localparam logic [LEVEL_W-1:0]   LEVEL_FULL  = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [LEVEL_W-1:0]   LEVEL_ZERO  = '0;
  localparam logic [DIV_CNT_W-1:0] STEPS_LEVEL = DIV_CNT_W'(FRAC_W + 1);
  localparam logic [DIV_CNT_W-1:0] STEPS_CEIL  = DIV_CNT_W'(TIME_W);

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ATTACK,
    OP_RELEASE
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ATTACK,
    PH_SUSTAIN,
    PH_RELEASE
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_TIME,
    CFG_RELEASE_TIME
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ELAPSED,
    S_DIFF,
    S_MUL,
    S_LDC,
    S_DIVC,
    S_FIX,
    S_TICK,
    S_DIVL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic trig_attack;
    logic trig_release;
    logic calc_elapsed;
    logic calc_diff;
    logic calc_prod;
    logic div_ceil;
    logic fix_start;
    logic tick_full;
    logic tick_zero;
    logic div_level;
    logic level_write;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    phase_t     phase;
    logic       e_gt_t1;
    logic       e_gt_t2;
    logic       div_done;
  } sts_t;

endpackage

>>> src/asr_envelope_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asr_envelope_generator
// Linear attack-sustain-release envelope, one result per input item.
//
// Input channel in_valid/in_ready carries an opcode (tick, attack, release)
// and the current time in ms; each transfer yields one result transfer on
// out_valid/out_ready with the phase and the Q16 level after that item.
// Durations are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// Items are handled one at a time. When the level ramps, the result waits
// on 17 divider steps; in idle or sustain, or when a ramp ends, none runs.
// A release during the attack first runs a 32-step division for the
// start-time correction and then goes on as a release.
// The next item is taken in the cycle after the result is loaded.
// Both divisions use the shared divider, one quotient bit per cycle.
// A finished result sits in the output register; the next item is taken
// while it waits, and that item holds in its last step until the receiver
// has taken the earlier result. Synchronous reset puts the envelope idle at
// level 0 and both durations at 1000 ms.
// ----------------------------------------------------------------------------
module asr_envelope_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic [asr_pkg::TIME_W-1:0]      in_now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_phase_code,
  output logic [asr_pkg::LEVEL_W-1:0]     out_level,
  input  logic                            cfg_we,
  input  logic [asr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asr_pkg::CFG_W-1:0]       cfg_data
);
  import asr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  asr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  asr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_now_ms      (in_now_ms),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_phase_code (out_phase_code),
    .out_level      (out_level)
  );

endmodule

>>> src/asr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asr_div
// Restoring divider, one quotient bit per cycle. The upper dividend word must
// be below the divisor; the lower word is shifted in for the given step count.
// ----------------------------------------------------------------------------
module asr_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [asr_pkg::TIME_W-1:0]      hi,
  input  logic [asr_pkg::TIME_W-1:0]      lo,
  input  logic [asr_pkg::TIME_W-1:0]      den,
  input  logic [asr_pkg::DIV_CNT_W-1:0]   steps,
  output logic                            done,
  output logic [asr_pkg::TIME_W-1:0]      quot,
  output logic                            rem_nz
);
  import asr_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TIME_W-1:0]    rem_r;
  logic [TIME_W-1:0]    lo_r;
  logic [TIME_W-1:0]    den_r;
  logic [TIME_W-1:0]    quot_r;
  logic [TIME_W:0]      trial;
  logic                 ge;
  logic [TIME_W:0]      diff;

  assign trial = {rem_r, lo_r[TIME_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= steps;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= hi;
      lo_r   <= lo;
      den_r  <= den;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      lo_r   <= {lo_r[TIME_W-2:0], 1'b0};
      quot_r <= {quot_r[TIME_W-2:0], ge};
    end
  end

  assign done   = cnt_r == '0;
  assign quot   = quot_r;
  assign rem_nz = rem_r != '0;

endmodule

>>> src/asr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asr_dp
// Envelope datapath: duration registers, envelope state, elapsed time, the
// release-during-attack product, the shared divider and the result register.
// ----------------------------------------------------------------------------
module asr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  asr_pkg::cmd_t                     cmd,
  output asr_pkg::sts_t                     sts,
  input  logic [1:0]                        in_opcode,
  input  logic [asr_pkg::TIME_W-1:0]        in_now_ms,
  input  logic                              cfg_we,
  input  logic [asr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asr_pkg::CFG_W-1:0]         cfg_data,
  output logic [1:0]                        out_phase_code,
  output logic [asr_pkg::LEVEL_W-1:0]       out_level
);
  import asr_pkg::*;

  logic [TIME_W-1:0]    attack_r;
  logic [TIME_W-1:0]    release_r;
  logic [CFG_W-1:0]     cfg_dur;
  phase_t               phase_r;
  logic [TIME_W-1:0]    start_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [1:0]           op_r;
  logic [TIME_W-1:0]    now_r;
  logic [TIME_W-1:0]    e_r;
  logic [TIME_W-1:0]    diff_r;
  logic [2*TIME_W-1:0]  prod_r;
  logic [1:0]           out_phase_r;
  logic [LEVEL_W-1:0]   out_level_r;

  logic                 e_gt_t1;
  logic                 e_gt_t2;
  logic                 div_start;
  logic                 div_done;
  logic                 rem_nz;
  logic [TIME_W-1:0]    quot;
  logic [TIME_W-1:0]    num;
  logic [TIME_W-1:0]    div_hi;
  logic [TIME_W-1:0]    div_lo;
  logic [TIME_W-1:0]    div_den;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [TIME_W-1:0]    back_off;

  // a zero duration counts as one millisecond
  assign cfg_dur = (cfg_data == '0) ? CFG_W'(1) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= DUR_RESET;
      release_r <= DUR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ATTACK_TIME:  attack_r  <= cfg_dur;
        CFG_RELEASE_TIME: release_r <= cfg_dur;
        default: ;
      endcase
    end
  end

  assign e_gt_t1 = e_r > attack_r;
  assign e_gt_t2 = e_r > release_r;

  always_comb begin
    num = (phase_r == PH_ATTACK) ? e_r : release_r - e_r;
    if (cmd.div_ceil) begin
      div_hi    = prod_r[2*TIME_W-1:TIME_W];
      div_lo    = prod_r[TIME_W-1:0];
      div_den   = attack_r;
      div_steps = STEPS_CEIL;
    end else begin
      // numerator never exceeds the divisor, so pre-shift by one
      div_hi    = {1'b0, num[TIME_W-1:1]};
      div_lo    = {num[0], {(TIME_W-1){1'b0}}};
      div_den   = (phase_r == PH_ATTACK) ? attack_r : release_r;
      div_steps = STEPS_LEVEL;
    end
  end

  assign div_start = cmd.div_ceil | cmd.div_level;
  assign back_off  = quot + TIME_W'(rem_nz);

  asr_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .hi     (div_hi),
    .lo     (div_lo),
    .den    (div_den),
    .steps  (div_steps),
    .done   (div_done),
    .quot   (quot),
    .rem_nz (rem_nz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      start_r <= '0;
      level_r <= LEVEL_ZERO;
    end else begin
      if (cmd.trig_attack) begin
        phase_r <= PH_ATTACK;
        start_r <= now_r;
      end
      if (cmd.trig_release) begin
        phase_r <= PH_RELEASE;
        start_r <= now_r;
      end
      if (cmd.fix_start) begin
        phase_r <= PH_RELEASE;
        start_r <= now_r - back_off;
      end
      if (cmd.tick_full) begin
        phase_r <= PH_SUSTAIN;
        level_r <= LEVEL_FULL;
      end
      if (cmd.tick_zero) begin
        phase_r <= PH_IDLE;
        level_r <= LEVEL_ZERO;
      end
      if (cmd.level_write) begin
        level_r <= quot[LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      now_r <= in_now_ms;
    end
    if (cmd.calc_elapsed) begin
      e_r <= now_r - start_r;
    end
    if (cmd.calc_diff) begin
      diff_r <= attack_r - (e_gt_t1 ? attack_r : e_r);
    end
    if (cmd.calc_prod) begin
      prod_r <= (2*TIME_W)'(release_r) * (2*TIME_W)'(diff_r);
    end
    if (cmd.load_out) begin
      out_phase_r <= phase_r;
      out_level_r <= level_r;
    end
  end

  assign sts.op       = op_r;
  assign sts.phase    = phase_r;
  assign sts.e_gt_t1  = e_gt_t1;
  assign sts.e_gt_t2  = e_gt_t2;
  assign sts.div_done = div_done;

  assign out_phase_code = out_phase_r;
  assign out_level      = out_level_r;

endmodule

>>> src/asr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asr_ctrl
// Sequencer for one item: trigger handling, elapsed time, optional start-time
// correction, level division and hand-off to the result register.
// ----------------------------------------------------------------------------
module asr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  asr_pkg::sts_t sts,
  output asr_pkg::cmd_t cmd
);
  import asr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op == OP_ATTACK) begin
          cmd.trig_attack = 1'b1;
        end else if (sts.op == OP_RELEASE && sts.phase == PH_SUSTAIN) begin
          cmd.trig_release = 1'b1;
        end
        state_nxt = S_ELAPSED;
      end
      S_ELAPSED: begin
        cmd.calc_elapsed = 1'b1;
        if (sts.op == OP_RELEASE && sts.phase == PH_ATTACK) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_TICK;
        end
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.calc_prod = 1'b1;
        state_nxt     = S_LDC;
      end
      S_LDC: begin
        cmd.div_ceil = 1'b1;
        state_nxt    = S_DIVC;
      end
      S_DIVC: begin
        if (sts.div_done) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix_start = 1'b1;
        state_nxt     = S_ELAPSED;
      end
      S_TICK: begin
        case (sts.phase)
          PH_ATTACK: begin
            if (sts.e_gt_t1) begin
              cmd.tick_full = 1'b1;
              state_nxt     = S_OUT;
            end else begin
              cmd.div_level = 1'b1;
              state_nxt     = S_DIVL;
            end
          end
          PH_RELEASE: begin
            if (sts.e_gt_t2) begin
              cmd.tick_zero = 1'b1;
              state_nxt     = S_OUT;
            end else begin
              cmd.div_level = 1'b1;
              state_nxt     = S_DIVL;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_DIVL: begin
        if (sts.div_done) begin
          cmd.level_write = 1'b1;
          state_nxt       = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;
  assign in_ready      = state_r == S_IDLE;
  assign out_valid     = out_valid_r;

endmodule

>>> dv/asr_envelope_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asr_envelope_generator_tb
// Self-checking bench for the linear attack-sustain-release envelope.
// A directed table covers reset, ramp ends, phase changes, time wrap and the
// release-during-attack correction. Random item runs follow under several
// duration settings, from 0 and 1 ms up to full scale. Both handshake sides
// stall at random, and every result transfer is compared with its expected
// result, taken from a fixed table row or from a local envelope model.
// ----------------------------------------------------------------------------
module asr_envelope_generator_tb;
  import asr_pkg::*;

  localparam logic [1:0] OP_SPARE      = 2'd3;
  localparam int         STALL_PCT     = 23;
  localparam int         IDLE_LIMIT    = 4000;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         RUN_ITEMS     = 75;
  localparam int         N_DIRECTED    = 25;
  localparam int         N_SETTINGS    = 8;

  typedef struct packed {
    phase_t             ph;
    logic [LEVEL_W-1:0] lvl;
  } env_sample_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [TIME_W-1:0]  now;
    logic               fixed;
    phase_t             ph;
    logic [LEVEL_W-1:0] lvl;
  } dir_row_t;

  // rows flagged fixed carry their own result, the rest use the model
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_TICK,    32'd0,         1'b1, PH_IDLE,    LEVEL_ZERO},
    '{OP_RELEASE, 32'd5,         1'b1, PH_IDLE,    LEVEL_ZERO},
    '{OP_SPARE,   32'd7,         1'b1, PH_IDLE,    LEVEL_ZERO},
    '{OP_ATTACK,  32'd100,       1'b1, PH_ATTACK,  LEVEL_ZERO},
    '{OP_TICK,    32'd600,       1'b0, PH_IDLE,    LEVEL_ZERO},
    '{OP_TICK,    32'd1100,      1'b1, PH_ATTACK,  LEVEL_FULL},
    '{OP_TICK,    32'd1101,      1'b1, PH_SUSTAIN, LEVEL_FULL},
    '{OP_SPARE,   32'd1200,      1'b1, PH_SUSTAIN, LEVEL_FULL},
    '{OP_ATTACK,  32'd1300,      1'b1, PH_ATTACK,  LEVEL_ZERO},
    '{OP_ATTACK,  32'd1800,      1'b1, PH_ATTACK,  LEVEL_ZERO},
    '{OP_TICK,    32'd5000,      1'b1, PH_SUSTAIN, LEVEL_FULL},
    '{OP_RELEASE, 32'd6000,      1'b1, PH_RELEASE, LEVEL_FULL},
    '{OP_RELEASE, 32'd6300,      1'b0, PH_IDLE,    LEVEL_ZERO},
    '{OP_TICK,    32'd7001,      1'b1, PH_IDLE,    LEVEL_ZERO},
    '{OP_ATTACK,  32'hFFFF_FF00, 1'b1, PH_ATTACK,  LEVEL_ZERO},
    '{OP_TICK,    32'h0000_00F0, 1'b0, PH_IDLE,    LEVEL_ZERO},
    '{OP_RELEASE, 32'h0000_0100, 1'b0, PH_IDLE,    LEVEL_ZERO},
    '{OP_TICK,    32'h0000_0200, 1'b0, PH_IDLE,    LEVEL_ZERO},
    '{OP_ATTACK,  32'hFFFF_FFFF, 1'b1, PH_ATTACK,  LEVEL_ZERO},
    '{OP_RELEASE, 32'hFFFF_FFFF, 1'b0, PH_IDLE,    LEVEL_ZERO},
    '{OP_TICK,    32'h0000_0400, 1'b0, PH_IDLE,    LEVEL_ZERO},
    '{OP_ATTACK,  32'd20000,     1'b1, PH_ATTACK,  LEVEL_ZERO},
    '{OP_RELEASE, 32'd90000,     1'b1, PH_RELEASE, LEVEL_FULL},
    '{OP_TICK,    32'd90500,     1'b0, PH_IDLE,    LEVEL_ZERO},
    '{OP_TICK,    32'hFFFF_FFFF, 1'b0, PH_IDLE,    LEVEL_ZERO}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_opcode;
  logic [TIME_W-1:0]    in_now_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_phase_code;
  logic [LEVEL_W-1:0]   out_level;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // local envelope model state
  logic [CFG_W-1:0]     atk_ms;
  logic [CFG_W-1:0]     rel_ms;
  phase_t               env_phase;
  logic [TIME_W-1:0]    env_start;
  logic [LEVEL_W-1:0]   env_level;

  env_sample_t          env_sample_q [$];
  int                   mismatch_count = 0;
  int                   idle_cycles = 0;
  logic                 calm = 1'b0;

  asr_envelope_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_phase_code (out_phase_code),
    .out_level      (out_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic env_sample_t envelope_advance(input logic [1:0] op,
                                                   input logic [TIME_W-1:0] now);
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] d;
    env_sample_t r;
    t1 = (atk_ms == '0) ? 64'd1 : {32'd0, atk_ms};
    t2 = (rel_ms == '0) ? 64'd1 : {32'd0, rel_ms};
    if (op == OP_ATTACK) begin
      env_phase = PH_ATTACK;
      env_start = now;
    end else if (op == OP_RELEASE) begin
      if (env_phase == PH_SUSTAIN) begin
        env_start = now;
        env_phase = PH_RELEASE;
      end else if (env_phase == PH_ATTACK) begin
        // shift the start back so the fall continues from the current level
        e = {32'd0, now - env_start};
        if (e > t1) e = t1;
        p = t2 * (t1 - e);
        d = p / t1 + (((p % t1) != 64'd0) ? 64'd1 : 64'd0);
        env_start = now - d[TIME_W-1:0];
        env_phase = PH_RELEASE;
      end
    end
    e = {32'd0, now - env_start};
    if (env_phase == PH_ATTACK) begin
      if (e > t1) begin
        env_level = LEVEL_FULL;
        env_phase = PH_SUSTAIN;
      end else begin
        env_level = LEVEL_W'((e << FRAC_W) / t1);
      end
    end else if (env_phase == PH_RELEASE) begin
      if (e > t2) begin
        env_level = LEVEL_ZERO;
        env_phase = PH_IDLE;
      end else begin
        env_level = LEVEL_W'(((t2 - e) << FRAC_W) / t2);
      end
    end
    r.ph  = env_phase;
    r.lvl = env_level;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [TIME_W-1:0] now,
                           input logic fixed, input env_sample_t typed);
    env_sample_t pred;
    while (!calm && ($urandom_range(0, 99) < STALL_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = envelope_advance(op, now);
    env_sample_q.push_back(fixed ? typed : pred);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (env_sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_durations(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ATTACK_TIME;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= CFG_RELEASE_TIME;
    cfg_data  <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    atk_ms = a;
    rel_ms = r;
  endtask

  // result side: random back-pressure and comparison
  always @(posedge clk) begin
    env_sample_t want;
    if (rst_n && (out_valid === 1'b1) && out_ready) begin
      if (env_sample_q.size() == 0) begin
        $error("unexpected result transfer: phase_code %0d level %0d",
               out_phase_code, out_level);
        mismatch_count++;
      end else begin
        want = env_sample_q.pop_front();
        if (out_phase_code !== want.ph) begin
          $error("phase_code: expected %0d, actual %0d", want.ph, out_phase_code);
          mismatch_count++;
        end
        if (out_level !== want.lvl) begin
          $error("level: expected %0d, actual %0d", want.lvl, out_level);
          mismatch_count++;
        end
      end
    end
    out_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && (in_ready === 1'b1)) || ((out_valid === 1'b1) && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] t_ms;
    logic [1:0]        op;
    int                pick;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_opcode <= OP_TICK;
    in_now_ms <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ATTACK_TIME;
    cfg_data  <= '0;
    atk_ms    = DUR_RESET;
    rel_ms    = DUR_RESET;
    env_phase = PH_IDLE;
    env_start = '0;
    env_level = LEVEL_ZERO;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(DIRECTED[i].op, DIRECTED[i].now, DIRECTED[i].fixed,
                {DIRECTED[i].ph, DIRECTED[i].lvl});
    end

    for (int s = 0; s < N_SETTINGS; s++) begin
      drain_and_settle();
      case (s)
        0: program_durations('0, '0);
        1: program_durations(32'd1, 32'd1);
        2: program_durations('1, '1);
        3: program_durations(32'd1, '1);
        4: program_durations('1, 32'd1);
        5, 6: program_durations($urandom_range(2, 300), $urandom_range(2, 300));
        default: program_durations($urandom, $urandom);
      endcase
      // one run without any stalls on either side
      calm <= (s == 5);
      t_ms = $urandom;
      for (int k = 0; k < RUN_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) op = OP_TICK;
        else if (pick < 73) op = OP_ATTACK;
        else if (pick < 93) op = OP_RELEASE;
        else op = OP_SPARE;
        // steps scaled to the ramps, with the odd jump across the whole range
        pick = $urandom_range(0, 9);
        if (pick < 4) t_ms = t_ms + $urandom_range(0, 3);
        else if (pick < 7) t_ms = t_ms + $urandom_range(0, (atk_ms >> 1) + 1);
        else if (pick < 9) t_ms = t_ms + $urandom_range(0, (rel_ms >> 1) + 1);
        else t_ms = t_ms + $urandom;
        send_item(op, t_ms, 1'b0, '0);
      end
    end
    calm <= 1'b0;
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
